// File: sv/rssa_pkg.sv
// Shared types and constants for the RSSI sweep averager with peak hold.
`timescale 1ns / 1ps

package rssa_pkg;

   // Number of channel bins in one sweep (2 to 128).
   localparam int BINS  = 100;
   localparam int BIN_W = (BINS > 2) ? $clog2(BINS) : 1;

   // Port field widths.
   localparam int RAW_W   = 7;
   localparam int CHAN_W  = 7;
   localparam int MEAN_W  = 12;
   localparam int LEVEL_W = 8;
   localparam int SHIFT_W = 3;
   localparam int SWEEP_W = 8;
   localparam int CSR_W   = 8;
   localparam int CSR_IDX_W = 2;

   // Register reset values.
   localparam logic [LEVEL_W-1:0] LOW_CLAMP_RST   = 8'hB0;  // -80 dBm
   localparam logic [LEVEL_W-1:0] HIGH_CLAMP_RST  = 8'hCE;  // -50 dBm
   localparam logic [SHIFT_W-1:0] IIR_SHIFT_RST   = 3'd1;
   localparam logic [SWEEP_W-1:0] SWEEP_LIMIT_RST = 8'd25;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOW_CLAMP   = 2'd0,
      CSR_HIGH_CLAMP  = 2'd1,
      CSR_IIR_SHIFT   = 2'd2,
      CSR_SWEEP_LIMIT = 2'd3
   } csr_index_type;

   // Contents of one bin: IIR mean (4 fraction bits) and peak in whole dBm.
   typedef struct packed {
      logic [MEAN_W-1:0]  mean;
      logic [LEVEL_W-1:0] peak;
   } bin_type;

   // Settings the update unit sees.
   typedef struct packed {
      logic [LEVEL_W-1:0] low_clamp;
      logic [LEVEL_W-1:0] high_clamp;
      logic [SHIFT_W-1:0] iir_shift;
      logic               first_sweep;
   } upd_ctrl_type;

endpackage

// File: sv/rssa_cell.sv
// One bin cell of the rotating chain: holds a mean and a peak, loads from its neighbor.
`timescale 1ns / 1ps

module rssa_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_en,
   input  rssa_pkg::bin_type bin_in,
   output rssa_pkg::bin_type bin_out
);

   logic [rssa_pkg::MEAN_W-1:0]  mean_ff;
   logic [rssa_pkg::LEVEL_W-1:0] peak_ff;

   // Mean starts at zero; peak is written in the first sweep before any read.
   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff <= '0;
      end else if (shift_en) begin
         mean_ff <= bin_in.mean;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         peak_ff <= bin_in.peak;
      end
   end

   assign bin_out.mean = mean_ff;
   assign bin_out.peak = peak_ff;

endmodule

// File: sv/rssa_update.sv
// Clamp a raw reading and fold it into one bin's IIR mean and peak.
`timescale 1ns / 1ps

module rssa_update (
   input  logic [rssa_pkg::RAW_W-1:0] rssi_raw,
   input  rssa_pkg::upd_ctrl_type     ctrl,
   input  rssa_pkg::bin_type          bin_old,
   output rssa_pkg::bin_type          bin_new
);

   logic signed [rssa_pkg::LEVEL_W-1:0]  reading;
   logic signed [rssa_pkg::LEVEL_W-1:0]  level;
   logic signed [rssa_pkg::MEAN_W-1:0]   target;
   logic signed [rssa_pkg::MEAN_W:0]     diff;
   logic signed [rssa_pkg::MEAN_W:0]     step;
   logic signed [rssa_pkg::MEAN_W:0]     sum;

   always_comb begin
      reading = -$signed({1'b0, rssi_raw});
      priority if (reading < $signed(ctrl.low_clamp)) begin
         level = $signed(ctrl.low_clamp);
      end else if (reading > $signed(ctrl.high_clamp)) begin
         level = $signed(ctrl.high_clamp);
      end else begin
         level = reading;
      end

      // Step toward level*16; the arithmetic shift rounds toward minus infinity.
      target = $signed({level, 4'b0000});
      diff   = (rssa_pkg::MEAN_W+1)'(target) - (rssa_pkg::MEAN_W+1)'($signed(bin_old.mean));
      step   = diff >>> ctrl.iir_shift;
      sum    = (rssa_pkg::MEAN_W+1)'($signed(bin_old.mean)) + step;
      bin_new.mean = sum[rssa_pkg::MEAN_W-1:0];

      if (ctrl.first_sweep || (level > $signed(bin_old.peak))) begin
         bin_new.peak = level;
      end else begin
         bin_new.peak = bin_old.peak;
      end
   end

endmodule

// File: sv/rssi_sweep_average_peak_hold.sv
// Top level of the RSSI sweep averager with peak hold.
`timescale 1ns / 1ps
//
// Usage:
//   Feed one raw RSSI reading per req_ transaction (req_rssi_raw = n means -n dBm)
//   for the channel named by the previous rsp_next_channel (channel 0 after reset).
//   Each reading yields one rsp_ transaction: the bin it updated, that bin's new
//   IIR mean (4 fraction bits), its peak, the next channel to tune and the sweep
//   number the reading fell in.
//   The response is registered; throughput is one reading per cycle unless a
//   held response stalls the input. The bins live in a ring of cells that
//   rotates by one place per transaction, so the bin being tuned always sits
//   at the head cell, and one read-modify-write of it per cycle sets the rate.
//   The response sits in an output register; a new request is taken while the
//   receiver takes the held response, and req_ready drops only while a response
//   waits with rsp_ready low.
//   Reset (synchronous) clears all means, the channel and sweep counters, the
//   response valid, and loads the registers with their defaults. The csr_
//   port must be written only while the block is idle; it does not enforce this.
//
module rssi_sweep_average_peak_hold (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wen,
   input  logic [rssa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rssa_pkg::CSR_W-1:0]        csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [rssa_pkg::RAW_W-1:0]        req_rssi_raw,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rssa_pkg::CHAN_W-1:0]       rsp_bin_index,
   output logic signed [rssa_pkg::MEAN_W-1:0] rsp_mean_level,
   output logic signed [rssa_pkg::LEVEL_W-1:0] rsp_peak_level,
   output logic [rssa_pkg::CHAN_W-1:0]       rsp_next_channel,
   output logic [rssa_pkg::SWEEP_W-1:0]      rsp_sweep_index
);

   localparam int BINS  = rssa_pkg::BINS;
   localparam int BIN_W = rssa_pkg::BIN_W;

   // Configuration registers.
   logic [rssa_pkg::LEVEL_W-1:0] low_clamp_ff;
   logic [rssa_pkg::LEVEL_W-1:0] high_clamp_ff;
   logic [rssa_pkg::SHIFT_W-1:0] iir_shift_ff;
   logic [rssa_pkg::SWEEP_W-1:0] sweep_limit_ff;

   // Counters.
   logic [BIN_W-1:0]             bin_ff;
   logic [BIN_W-1:0]             bin_in;
   logic [rssa_pkg::SWEEP_W-1:0] sweep_ff;
   logic [rssa_pkg::SWEEP_W-1:0] sweep_in;
   logic [BIN_W:0]               bin_inc;
   logic [rssa_pkg::SWEEP_W:0]   sweep_inc;

   // Output register.
   logic                         rsp_valid_ff;
   logic [rssa_pkg::CHAN_W-1:0]  rsp_bin_ff;
   logic [rssa_pkg::MEAN_W-1:0]  rsp_mean_ff;
   logic [rssa_pkg::LEVEL_W-1:0] rsp_peak_ff;
   logic [rssa_pkg::CHAN_W-1:0]  rsp_next_ff;
   logic [rssa_pkg::SWEEP_W-1:0] rsp_sweep_ff;

   logic                         accept;
   rssa_pkg::upd_ctrl_type       upd_ctrl;
   rssa_pkg::bin_type            chain [BINS];
   rssa_pkg::bin_type            bin_new;

   // Take a request whenever the output register is empty or being emptied.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Registers load only on a write; codes beyond the list do not exist at this width.
   always_ff @(posedge clock) begin
      if (reset) begin
         low_clamp_ff   <= rssa_pkg::LOW_CLAMP_RST;
         high_clamp_ff  <= rssa_pkg::HIGH_CLAMP_RST;
         iir_shift_ff   <= rssa_pkg::IIR_SHIFT_RST;
         sweep_limit_ff <= rssa_pkg::SWEEP_LIMIT_RST;
      end else if (csr_wen) begin
         unique case (csr_index)
            rssa_pkg::CSR_LOW_CLAMP:   low_clamp_ff   <= csr_wdata;
            rssa_pkg::CSR_HIGH_CLAMP:  high_clamp_ff  <= csr_wdata;
            rssa_pkg::CSR_IIR_SHIFT:   iir_shift_ff   <= csr_wdata[rssa_pkg::SHIFT_W-1:0];
            rssa_pkg::CSR_SWEEP_LIMIT: sweep_limit_ff <= csr_wdata;
            default:                   ;
         endcase
      end
   end

   // Advance the channel; on wrap advance the sweep and drop it to zero past the limit.
   always_comb begin
      bin_inc   = {1'b0, bin_ff} + (BIN_W+1)'(1);
      sweep_inc = {1'b0, sweep_ff} + (rssa_pkg::SWEEP_W+1)'(1);
      bin_in    = bin_inc[BIN_W-1:0];
      sweep_in  = sweep_ff;
      if (bin_inc >= (BIN_W+1)'(BINS)) begin
         bin_in = '0;
         if (sweep_inc > {1'b0, sweep_limit_ff}) begin
            sweep_in = '0;
         end else begin
            sweep_in = sweep_inc[rssa_pkg::SWEEP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_ff   <= '0;
         sweep_ff <= '0;
      end else if (accept) begin
         bin_ff   <= bin_in;
         sweep_ff <= sweep_in;
      end
   end

   // Head cell holds the bin being tuned; update it and send it to the tail.
   assign upd_ctrl.low_clamp   = low_clamp_ff;
   assign upd_ctrl.high_clamp  = high_clamp_ff;
   assign upd_ctrl.iir_shift   = iir_shift_ff;
   assign upd_ctrl.first_sweep = (sweep_ff == '0);

   rssa_update u_update (
      .rssi_raw (req_rssi_raw),
      .ctrl     (upd_ctrl),
      .bin_old  (chain[0]),
      .bin_new  (bin_new)
   );

   // Rotate the ring by one cell per transaction.
   for (genvar i = 0; i < BINS; i++) begin : g_cell
      rssa_pkg::bin_type cell_in;
      if (i == BINS - 1) begin : g_tail
         assign cell_in = bin_new;
      end else begin : g_body
         assign cell_in = chain[i+1];
      end
      rssa_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (accept),
         .bin_in   (cell_in),
         .bin_out  (chain[i])
      );
   end

   // Output register: hold while stalled, load on every accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_bin_ff   <= rssa_pkg::CHAN_W'(bin_ff);
         rsp_mean_ff  <= bin_new.mean;
         rsp_peak_ff  <= bin_new.peak;
         rsp_next_ff  <= rssa_pkg::CHAN_W'(bin_in);
         rsp_sweep_ff <= sweep_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bin_index    = rsp_bin_ff;
   assign rsp_mean_level   = $signed(rsp_mean_ff);
   assign rsp_peak_level   = $signed(rsp_peak_ff);
   assign rsp_next_channel = rsp_next_ff;
   assign rsp_sweep_index  = rsp_sweep_ff;

endmodule

// File: sv/rssa_checker.sv
// Port-level checker for the RSSI sweep averager, bound to the top level.
`timescale 1ns / 1ps

module rssa_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [rssa_pkg::CHAN_W-1:0]        rsp_bin_index,
   input logic signed [rssa_pkg::MEAN_W-1:0] rsp_mean_level,
   input logic signed [rssa_pkg::LEVEL_W-1:0] rsp_peak_level,
   input logic [rssa_pkg::CHAN_W-1:0]        rsp_next_channel,
   input logic [rssa_pkg::SWEEP_W-1:0]       rsp_sweep_index
);

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_req_to_rsp : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted request gave no response next cycle");

   a_ready_stall : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request side stalled without a blocked response");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_bin_index)
         && $stable(rsp_mean_level) && $stable(rsp_peak_level)
         && $stable(rsp_next_channel) && $stable(rsp_sweep_index)))
      else $error("stalled response changed");

endmodule

bind rssi_sweep_average_peak_hold rssa_checker u_rssa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_bin_index    (rsp_bin_index),
   .rsp_mean_level   (rsp_mean_level),
   .rsp_peak_level   (rsp_peak_level),
   .rsp_next_channel (rsp_next_channel),
   .rsp_sweep_index  (rsp_sweep_index)
);

// File: tb/rssi_sweep_average_peak_hold_test.sv
// Self-checking testbench for the RSSI sweep averager with peak hold.
`timescale 1ns / 1ps

module rssi_sweep_average_peak_hold_test;

   // Abort when no transaction moves on either channel for this many cycles.
   // The longest planned hold-off on the response side comes from test_input_backpressure.
   localparam int STALL_LIMIT = 3000;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                csr_wen = 1'b0;
   logic [rssa_pkg::CSR_IDX_W-1:0]      csr_index = '0;
   logic [rssa_pkg::CSR_W-1:0]          csr_wdata = '0;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic [rssa_pkg::RAW_W-1:0]          req_rssi_raw = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic [rssa_pkg::CHAN_W-1:0]         rsp_bin_index;
   logic signed [rssa_pkg::MEAN_W-1:0]  rsp_mean_level;
   logic signed [rssa_pkg::LEVEL_W-1:0] rsp_peak_level;
   logic [rssa_pkg::CHAN_W-1:0]         rsp_next_channel;
   logic [rssa_pkg::SWEEP_W-1:0]        rsp_sweep_index;

   // One expected response: what a single reading does to its bin.
   typedef struct {
      logic [rssa_pkg::CHAN_W-1:0]         bin;
      logic signed [rssa_pkg::MEAN_W-1:0]  mean;
      logic signed [rssa_pkg::LEVEL_W-1:0] peak;
      logic [rssa_pkg::CHAN_W-1:0]         next_chan;
      logic [rssa_pkg::SWEEP_W-1:0]        sweep;
   } bin_update_type;

   bin_update_type expected_updates[$];

   // Shadow copy of the registers and the bin store.
   int low_level   = -80;
   int high_level  = -50;
   int iir_shift   = 1;
   int sweep_limit = 25;
   int mean_bins[rssa_pkg::BINS];
   int peak_bins[rssa_pkg::BINS];
   int cur_bin   = 0;
   int sweep_cnt = 0;

   // Knobs shared by the stimulus and the receiver.
   bit sender_idles   = 1'b0;
   bit receiver_idles = 1'b0;
   int hold_len       = 0;

   int mismatches        = 0;
   int readings_sent     = 0;
   int responses_checked = 0;
   int sweep_wraps       = 0;
   int csr_writes        = 0;

   rssi_sweep_average_peak_hold u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wen          (csr_wen),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rssi_raw     (req_rssi_raw),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_bin_index    (rsp_bin_index),
      .rsp_mean_level   (rsp_mean_level),
      .rsp_peak_level   (rsp_peak_level),
      .rsp_next_channel (rsp_next_channel),
      .rsp_sweep_index  (rsp_sweep_index)
   );

   always #4 clock = ~clock;

   initial begin
      for (int i = 0; i < rssa_pkg::BINS; i++) begin
         mean_bins[i] = 0;
         peak_bins[i] = 0;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // Apply one reading to the shadow store and queue the response it must cause.
   task automatic predict_update(input logic [rssa_pkg::RAW_W-1:0] raw);
      bin_update_type upd;
      int level;
      int mean;
      level = -int'(raw);
      // The low bound is checked first: in a crossed window, below low becomes low, the rest high.
      if (level < low_level)
         level = low_level;
      else if (level > high_level)
         level = high_level;
      upd.bin   = rssa_pkg::CHAN_W'(cur_bin);
      upd.sweep = rssa_pkg::SWEEP_W'(sweep_cnt);
      mean = mean_bins[cur_bin];
      // Arithmetic shift on a signed int floors toward minus infinity.
      mean = mean + ((level * 16 - mean) >>> iir_shift);
      mean_bins[cur_bin] = mean;
      upd.mean = rssa_pkg::MEAN_W'(mean);
      // Overwrite the peak in sweep 0, keep the maximum afterwards.
      if (sweep_cnt == 0 || level > peak_bins[cur_bin])
         peak_bins[cur_bin] = level;
      upd.peak = rssa_pkg::LEVEL_W'(peak_bins[cur_bin]);
      cur_bin++;
      if (cur_bin >= rssa_pkg::BINS) begin
         cur_bin = 0;
         sweep_cnt++;
         sweep_wraps++;
         if (sweep_cnt > sweep_limit)
            sweep_cnt = 0;
      end
      upd.next_chan = rssa_pkg::CHAN_W'(cur_bin);
      expected_updates.push_back(upd);
   endtask

   // Write one register while the block is idle and mirror it in the shadow copy.
   task automatic write_csr(input rssa_pkg::csr_index_type idx,
                            input logic [rssa_pkg::CSR_W-1:0] data);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      unique case (idx)
         rssa_pkg::CSR_LOW_CLAMP:   low_level   = int'($signed(data));
         rssa_pkg::CSR_HIGH_CLAMP:  high_level  = int'($signed(data));
         rssa_pkg::CSR_IIR_SHIFT:   iir_shift   = int'(data[rssa_pkg::SHIFT_W-1:0]);
         rssa_pkg::CSR_SWEEP_LIMIT: sweep_limit = int'(data);
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic write_all_csr(input int low, input int high, input int shift,
                                input int limit);
      write_csr(rssa_pkg::CSR_LOW_CLAMP, low[rssa_pkg::CSR_W-1:0]);
      write_csr(rssa_pkg::CSR_HIGH_CLAMP, high[rssa_pkg::CSR_W-1:0]);
      write_csr(rssa_pkg::CSR_IIR_SHIFT, shift[rssa_pkg::CSR_W-1:0]);
      write_csr(rssa_pkg::CSR_SWEEP_LIMIT, limit[rssa_pkg::CSR_W-1:0]);
   endtask

   // Offer one reading and hold it until the block takes it. Valid stays high
   // after acceptance; the next call either replaces the payload or drops valid.
   task automatic send_reading(input logic [rssa_pkg::RAW_W-1:0] raw);
      int gap;
      gap = (sender_idles && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_rssi_raw <= raw;
      do @(posedge clock); while (req_ready !== 1'b1);
      readings_sent++;
      predict_update(raw);
   endtask

   // Drop valid, wait for every response, then let the output pipe drain.
   task automatic settle_block;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_updates.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Pick a reading: half uniform, the rest at the field extremes or the window edges.
   function automatic logic [rssa_pkg::RAW_W-1:0] pick_raw;
      int r;
      case ($urandom_range(0, 7))
         0: r = 0;
         1: r = 127;
         2: r = -low_level + int'($urandom_range(0, 2)) - 1;
         3: r = -high_level + int'($urandom_range(0, 2)) - 1;
         default: r = $urandom_range(0, 127);
      endcase
      if (r < 0) r = 0;
      if (r > 127) r = 127;
      return r[rssa_pkg::RAW_W-1:0];
   endfunction

   // Field extremes, clamp edges, crossed window and both shift extremes.
   task automatic test_directed_extremes;
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      // Reset window -80..-50 dBm with shift 1: probe both sides of each edge.
      send_reading(7'd0);
      send_reading(7'd127);
      send_reading(7'd80);
      send_reading(7'd81);
      send_reading(7'd79);
      send_reading(7'd50);
      send_reading(7'd49);
      send_reading(7'd51);
      settle_block();
      // Full window.
      write_all_csr(-128, 0, 1, 25);
      send_reading(7'd0);
      send_reading(7'd127);
      send_reading(7'd64);
      settle_block();
      // Crossed window: below low becomes low, everything else high.
      write_all_csr(-40, -90, 1, 25);
      send_reading(7'd30);
      send_reading(7'd60);
      send_reading(7'd40);
      send_reading(7'd90);
      send_reading(7'd127);
      send_reading(7'd0);
      settle_block();
      // Zero shift replaces the mean outright; swing it across its full range.
      write_all_csr(-128, 0, 0, 25);
      send_reading(7'd127);
      send_reading(7'd0);
      send_reading(7'd100);
      settle_block();
      // Window pinned at -128 drives the mean to its most negative value.
      write_all_csr(-128, -128, 0, 25);
      send_reading(7'd0);
      settle_block();
      // Slowest averaging.
      write_all_csr(-128, 0, 7, 25);
      send_reading(7'd127);
      send_reading(7'd127);
      send_reading(7'd0);
      settle_block();
   endtask

   // Random readings under a new register setting per phase, idling on both sides.
   task automatic test_random_settings(input int phases, input int per_phase);
      int low;
      int high;
      int shift;
      int limit;
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      for (int p = 0; p < phases; p++) begin
         case (p % 4)
            0: begin
               low = -128; high = 0; shift = 0; limit = 0;
            end
            1: begin
               low = 0; high = -128; shift = 7; limit = 255;
            end
            default: begin
               low   = -int'($urandom_range(0, 128));
               high  = -int'($urandom_range(0, 128));
               shift = $urandom_range(0, 7);
               limit = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 3);
            end
         endcase
         // Narrow windows are rare at random; make some phases use one.
         if (p % 4 == 3) high = low + int'($urandom_range(0, 3));
         if (high > 0) high = 0;
         write_all_csr(low, high, shift, limit);
         repeat (per_phase) send_reading(pick_raw());
         settle_block();
      end
   endtask

   // Write a sweep limit below the running sweep count; the next wrap must reset it.
   task automatic test_lowered_limit;
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      write_all_csr(-110, -20, 2, 255);
      while (sweep_cnt < 2) send_reading(pick_raw());
      settle_block();
      write_csr(rssa_pkg::CSR_SWEEP_LIMIT, 8'd1);
      while (sweep_cnt != 0) send_reading(pick_raw());
      repeat (10) send_reading(pick_raw());
      settle_block();
   endtask

   // Hold the receiver off for a long stretch while readings keep coming,
   // so the output register fills and the block stalls its input.
   task automatic test_input_backpressure;
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      hold_len       = 400;
      repeat (40) send_reading(pick_raw());
      settle_block();
   endtask

   // Back-to-back traffic with no idling on either side.
   task automatic test_streaming;
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      write_all_csr(-100, -30, 3, 1);
      repeat (200) send_reading(pick_raw());
      settle_block();
   endtask

   // Receiver: drive rsp_ready at the falling edge. A requested hold-off wins
   // over the random stall bursts.
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (hold_len > 0) begin
            rsp_ready <= 1'b0;
            n = hold_len;
            hold_len = 0;
            repeat (n) @(negedge clock);
            rsp_ready <= 1'b1;
         end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Compare every accepted response with the oldest pending prediction.
   always @(posedge clock) begin
      bin_update_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (expected_updates.size() == 0) begin
            report_mismatch("response with nothing pending, bin_index",
                            int'(rsp_bin_index), 0);
         end else begin
            want = expected_updates.pop_front();
            responses_checked++;
            if (rsp_bin_index !== want.bin)
               report_mismatch("bin_index", int'(rsp_bin_index), int'(want.bin));
            if (rsp_mean_level !== want.mean)
               report_mismatch("mean_level", int'(rsp_mean_level), int'(want.mean));
            if (rsp_peak_level !== want.peak)
               report_mismatch("peak_level", int'(rsp_peak_level), int'(want.peak));
            if (rsp_next_channel !== want.next_chan)
               report_mismatch("next_channel", int'(rsp_next_channel),
                               int'(want.next_chan));
            if (rsp_sweep_index !== want.sweep)
               report_mismatch("sweep_index", int'(rsp_sweep_index), int'(want.sweep));
         end
      end
   end

   // Watchdog: count cycles in which neither channel moves a transaction.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_ready === 1'b1) ||
             (rsp_valid === 1'b1 && rsp_ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      // Hold reset, then release it at a falling edge.
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_extremes();
      test_random_settings(6, 100);
      test_lowered_limit();
      test_input_backpressure();
      test_streaming();

      // Drain the output pipe once more, then flag anything left pending.
      settle_block();
      if (expected_updates.size() != 0)
         report_mismatch("responses still pending", 0, expected_updates.size());

      $display("covered %0d readings, %0d checked responses, %0d sweep wraps",
               readings_sent, responses_checked, sweep_wraps);
      $display("with %0d register writes, crossed windows, lowered limits and stalls",
               csr_writes);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// File: files.f
sv/rssa_pkg.sv
sv/rssa_cell.sv
sv/rssa_update.sv
sv/rssi_sweep_average_peak_hold.sv
sv/rssa_checker.sv
tb/rssi_sweep_average_peak_hold_test.sv
